[sv/fdlp_pkg.sv]
// Shared types, constants and the coefficient table of the dual-channel FIR low-pass core.
`default_nettype none
package fdlp_pkg;

    localparam int TAPS        = 45;
    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 16;
    localparam int ROM_LEN     = 45;
    localparam int ACC_SHIFT   = 16;
    localparam int TAP_W       = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ROM_W       = $clog2(ROM_LEN);
    localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_BITS    = ACC_SHIFT + SAMPLE_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEFF_BITS-1:0]  t_coeff;
    typedef logic signed [PROD_BITS-1:0]   t_prod;
    typedef logic        [ACC_BITS-1:0]    t_acc;
    typedef logic        [TAP_W-1:0]       t_tap;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic shift;
        logic ch;
    } t_cell_ctl;

    typedef struct packed {
        logic load;
        logic rot;
        logic mul;
        logic out_load;
        logic ch;
        t_tap tap;
    } t_ctl;

    localparam t_coeff COEFF_ROM [ROM_LEN] = '{
        16'h0018, 16'h0055, 16'h0097, 16'h00D0, 16'h00EC, 16'h00D9, 16'h008A, 16'h0000,
        16'hFF45, 16'hFE75, 16'hFDB7, 16'hFD3D, 16'hFD37, 16'hFDCD, 16'hFF17, 16'h0114,
        16'h03AC, 16'h06AA, 16'h09C4, 16'h0CA7, 16'h0F00, 16'h1088, 16'h1110, 16'h1088,
        16'h0F00, 16'h0CA7, 16'h09C4, 16'h06AA, 16'h03AC, 16'h0114, 16'hFF17, 16'hFDCD,
        16'hFD37, 16'hFD3D, 16'hFDB7, 16'hFE75, 16'hFF45, 16'h0000, 16'h008A, 16'h00D9,
        16'h00EC, 16'h00D0, 16'h0097, 16'h0055, 16'h0018
    };

    function automatic t_coeff coeff_at(input t_tap tap);
        logic [ROM_W-1:0] idx;
        t_coeff           c;
        idx = ROM_W'(tap);
        if (32'(tap) < ROM_LEN) begin
            c = COEFF_ROM[idx];
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[sv/fdlp_ifs.sv]
// Valid/ready channel interfaces for the sample input and the filtered output.
`default_nettype none
interface fdlp_in_if;
    logic               valid;
    logic               ready;
    fdlp_pkg::t_sample  sample;
    logic               channel;

    modport source (output valid, output sample, output channel, input ready);
    modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface fdlp_out_if;
    logic               valid;
    logic               ready;
    fdlp_pkg::t_sample  filtered;
    logic               out_channel;

    modport source (output valid, output filtered, output out_channel, input ready);
    modport sink   (input valid, input filtered, input out_channel, output ready);
endinterface
`default_nettype wire

[sv/fdlp_cell.sv]
// One delay-line cell holding one sample per channel and passing it to its neighbor.
`default_nettype none
module fdlp_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fdlp_pkg::t_cell_ctl i_ctl,
    input  wire fdlp_pkg::t_sample   i_d,
    output fdlp_pkg::t_sample        o_q
);

    fdlp_pkg::t_sample r_smp [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp[0] <= '0;
            r_smp[1] <= '0;
        end else if (i_ctl.shift) begin
            r_smp[i_ctl.ch] <= i_d;
        end
    end

    assign o_q = r_smp[i_ctl.ch];

endmodule
`default_nettype wire

[sv/fdlp_mac.sv]
// Registered multiplier and accumulator fed one tap per cycle from the end of the cell chain.
`default_nettype none
module fdlp_mac (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fdlp_pkg::t_ctl    i_ctl,
    input  wire fdlp_pkg::t_sample i_smp,
    output fdlp_pkg::t_acc         o_acc
);

    fdlp_pkg::t_prod r_prod;
    logic            r_p_vld;
    fdlp_pkg::t_acc  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_smp * fdlp_pkg::coeff_at(i_ctl.tap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_ctl.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + fdlp_pkg::ACC_BITS'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

[sv/fdlp_ctrl.sv]
// Sequencer that loads a sample, rotates the cell chain once per tap and hands off the result.
`default_nettype none
module fdlp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ch,
    input  wire logic          i_out_free,
    output logic               o_in_ready,
    output fdlp_pkg::t_ctl     o_ctl
);

    fdlp_pkg::t_state r_state;
    fdlp_pkg::t_state n_state;
    fdlp_pkg::t_tap   r_step;
    fdlp_pkg::t_tap   n_step;
    logic             r_ch;
    logic             n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdlp_pkg::ST_IDLE;
            r_step  <= '0;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_ch    = r_ch;
        unique case (r_state)
            fdlp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fdlp_pkg::ST_RUN;
                    n_step  = fdlp_pkg::TAP_W'(fdlp_pkg::TAPS - 1);
                    n_ch    = i_in_ch;
                end
            end
            fdlp_pkg::ST_RUN: begin
                if (r_step == '0) begin
                    n_state = fdlp_pkg::ST_FLUSH;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            fdlp_pkg::ST_FLUSH: begin
                n_state = fdlp_pkg::ST_OUT;
            end
            fdlp_pkg::ST_OUT: begin
                if (i_out_free) begin
                    n_state = fdlp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fdlp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == fdlp_pkg::ST_IDLE);
        o_ctl.load     = (r_state == fdlp_pkg::ST_IDLE) && i_in_valid;
        o_ctl.rot      = (r_state == fdlp_pkg::ST_RUN);
        o_ctl.mul      = (r_state == fdlp_pkg::ST_RUN);
        o_ctl.out_load = (r_state == fdlp_pkg::ST_OUT) && i_out_free;
        o_ctl.ch       = (r_state == fdlp_pkg::ST_IDLE) ? i_in_ch : r_ch;
        o_ctl.tap      = r_step;
    end

endmodule
`default_nettype wire

[sv/dual_channel_fir_lowpass_core.sv]
// Top level of the dual-channel 45-tap Hann low-pass FIR core.
//
// Samples enter on i_in with a channel bit, 0 for in-phase and 1 for quadrature.
// Each channel has its own 45-sample delay line held in a chain of cells.
// A transaction on i_in shifts the sample into that channel's chain, after
// which the chain rotates once per tap while a single multiplier and
// accumulator consume the sample at the chain's end.
// One result per input leaves on o_out with the channel it belongs to.
// A new input is taken only after the previous pass ends, while o_out keeps up,
// since the single multiply-accumulate unit works through one tap per cycle.
// The result sits in an output register, so the next input is taken while a
// finished result still waits; if the receiver stalls longer, the core holds
// its result in the accumulator and stops taking input until the register frees.
// Synchronous reset clears both delay lines, the sequencer and the output valid.
`default_nettype none
module dual_channel_fir_lowpass_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    fdlp_in_if.sink        i_in,
    fdlp_out_if.source     o_out
);

    fdlp_pkg::t_ctl      w_ctl;
    fdlp_pkg::t_cell_ctl w_cell_ctl;
    fdlp_pkg::t_sample   w_q [fdlp_pkg::TAPS];
    fdlp_pkg::t_sample   w_chain_in;
    fdlp_pkg::t_acc      w_acc;
    logic                w_out_free;
    logic                w_in_ready;

    logic                r_out_vld;
    fdlp_pkg::t_sample   r_filt;
    logic                r_och;

    assign w_out_free = !r_out_vld || o_out.ready;

    fdlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_ch    (i_in.channel),
        .i_out_free (w_out_free),
        .o_in_ready (w_in_ready),
        .o_ctl      (w_ctl)
    );

    assign i_in.ready = w_in_ready;

    assign w_cell_ctl.shift = w_ctl.load || w_ctl.rot;
    assign w_cell_ctl.ch    = w_ctl.ch;
    assign w_chain_in       = w_ctl.load ? i_in.sample : w_q[fdlp_pkg::TAPS-1];

    for (genvar k = 0; k < fdlp_pkg::TAPS; k++) begin : g_cell
        if (k == 0) begin : g_head
            fdlp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cell_ctl),
                .i_d     (w_chain_in),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            fdlp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cell_ctl),
                .i_d     (w_q[k-1]),
                .o_q     (w_q[k])
            );
        end
    end

    fdlp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_smp   (w_q[fdlp_pkg::TAPS-1]),
        .o_acc   (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_filt <= w_acc[fdlp_pkg::ACC_BITS-1:fdlp_pkg::ACC_SHIFT];
            r_och  <= w_ctl.ch;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.filtered    = r_filt;
    assign o_out.out_channel = r_och;

endmodule
`default_nettype wire

[sv/fdlp_chk.sv]
// Port-level checker for the FIR core and the bind that attaches it.
`default_nettype none
module fdlp_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire fdlp_pkg::t_sample  i_out_filtered,
    input wire logic               i_out_channel
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while a filter pass runs");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared before the filter pass ended");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_filtered) && $stable(i_out_channel)))
        else $error("stalled output transaction changed");

endmodule

bind dual_channel_fir_lowpass_core fdlp_chk u_fdlp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_filtered (o_out.filtered),
    .i_out_channel  (o_out.out_channel)
);
`default_nettype wire
